### hdl/mfd_pkg.sv
// ----------------------------------------------------------------------------
// mfd_pkg
// Types and constants shared by the message frame deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package mfd_pkg;

    localparam int POS_W = 17;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    localparam logic [POS_W-1:0] POS_VERSION   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_TYPE      = POS_W'(1);
    localparam logic [POS_W-1:0] POS_TTL       = POS_W'(2);
    localparam logic [POS_W-1:0] POS_STAMP_END = POS_W'(11);
    localparam logic [POS_W-1:0] POS_FLAGS     = POS_W'(11);
    localparam logic [POS_W-1:0] POS_LEN_HI    = POS_W'(12);
    localparam logic [POS_W-1:0] POS_LEN_LO    = POS_W'(13);
    localparam int FIXED_HEADER_BYTES = 14;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 184;
    localparam int OUT_PAD_W   = 5;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        KIND_RECIPIENT = 2'd0,
        KIND_PAYLOAD   = 2'd1,
        KIND_SIGNATURE = 2'd2,
        KIND_SUMMARY   = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_VERSION   = 3'd2,
        ST_RECIPIENT = 3'd3,
        ST_PAYLOAD   = 3'd4,
        ST_SIGNATURE = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        REG_EXPECTED_VERSION = 2'd0,
        REG_RECIPIENT_MASK   = 2'd1,
        REG_SIGNATURE_MASK   = 2'd2,
        REG_MAX_PAYLOAD      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic [7:0]  expected_version;
        logic [7:0]  recipient_mask;
        logic [7:0]  signature_mask;
        logic [15:0] max_payload;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  frame_type;
        logic [7:0]  hop_limit;
        logic [63:0] time_stamp;
        logic [7:0]  flag_bits;
        logic [15:0] body_length;
        logic [63:0] sender;
    } header_t;

    typedef struct packed {
        logic    has_byte;
        kind_t   byte_kind;
        logic [7:0] data;
        logic    has_summary;
        status_t status;
        header_t header;
    } q_entry_t;

    typedef struct packed {
        kind_t   kind;
        logic [7:0] out_byte;
        status_t status;
        header_t header;
        logic    last;
    } result_t;

endpackage

`default_nettype wire

### hdl/mfd_front.sv
// ----------------------------------------------------------------------------
// mfd_front
// Tracks the byte position, captures the header and classifies each byte;
// pushes byte and summary work into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_front
    import mfd_pkg::*;
#(
    parameter int SENDER_ID_BYTES    = 8,
    parameter int RECIPIENT_ID_BYTES = 8,
    parameter int SIGNATURE_BYTES    = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_t     cfg,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire logic [7:0] in_byte,
    input  wire logic     in_last,
    input  wire logic     q_full,
    output logic          push,
    output q_entry_t      entry
);

    localparam logic [POS_W-1:0] HEADER_BYTES = POS_W'(FIXED_HEADER_BYTES + SENDER_ID_BYTES);
    localparam logic [POS_W-1:0] REC_BYTES    = POS_W'(RECIPIENT_ID_BYTES);
    localparam logic [POS_W-1:0] SIG_BYTES    = POS_W'(SIGNATURE_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [7:0]       version_reg, version_next;
    header_t          hdr_reg, hdr_next;

    logic             in_fire;
    logic             has_rec;
    logic             has_sig;
    logic [POS_W-1:0] end_rec;
    logic [POS_W-1:0] end_pay;
    logic [POS_W-1:0] end_sig;
    logic [POS_W:0]   frame_len;
    logic             emit;
    kind_t            emit_kind;
    status_t          status;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;

    assign has_rec   = |(hdr_reg.flag_bits & cfg.recipient_mask);
    assign has_sig   = |(hdr_reg.flag_bits & cfg.signature_mask);
    assign end_rec   = HEADER_BYTES + (has_rec ? REC_BYTES : '0);
    assign end_pay   = end_rec + POS_W'(hdr_reg.body_length);
    assign end_sig   = end_pay + (has_sig ? SIG_BYTES : '0);
    assign frame_len = {1'b0, pos_reg} + (POS_W+1)'(1);

    always_comb
    begin
        hdr_next     = hdr_reg;
        version_next = version_reg;
        if (pos_reg == POS_VERSION)
        begin
            version_next = in_byte;
        end
        else if (pos_reg == POS_TYPE)
        begin
            hdr_next.frame_type = in_byte;
        end
        else if (pos_reg == POS_TTL)
        begin
            hdr_next.hop_limit = in_byte;
        end
        else if (pos_reg < POS_STAMP_END)
        begin
            hdr_next.time_stamp = {hdr_reg.time_stamp[55:0], in_byte};
        end
        else if (pos_reg == POS_FLAGS)
        begin
            hdr_next.flag_bits = in_byte;
        end
        else if (pos_reg == POS_LEN_HI)
        begin
            hdr_next.body_length = {in_byte, hdr_reg.body_length[7:0]};
        end
        else if (pos_reg == POS_LEN_LO)
        begin
            hdr_next.body_length = {hdr_reg.body_length[15:8], in_byte};
        end
        else if (pos_reg < HEADER_BYTES)
        begin
            hdr_next.sender = {hdr_reg.sender[55:0], in_byte};
        end
    end

    always_comb
    begin
        emit      = 1'b0;
        emit_kind = KIND_PAYLOAD;
        if (pos_reg >= HEADER_BYTES)
        begin
            if (has_rec && (pos_reg < end_rec))
            begin
                emit      = 1'b1;
                emit_kind = KIND_RECIPIENT;
            end
            else if (pos_reg < end_pay)
            begin
                emit      = (hdr_reg.body_length <= cfg.max_payload);
                emit_kind = KIND_PAYLOAD;
            end
            else if (has_sig && (pos_reg < end_sig))
            begin
                emit      = 1'b1;
                emit_kind = KIND_SIGNATURE;
            end
        end
    end

    always_comb
    begin
        if (frame_len < {1'b0, HEADER_BYTES})
        begin
            status = ST_SHORT;
        end
        else if (version_next != cfg.expected_version)
        begin
            status = ST_VERSION;
        end
        else if (has_rec && ({1'b0, end_rec} > frame_len))
        begin
            status = ST_RECIPIENT;
        end
        else if ((hdr_reg.body_length != 16'd0)
                 && (({1'b0, end_pay} > frame_len)
                     || (hdr_reg.body_length > cfg.max_payload)))
        begin
            status = ST_PAYLOAD;
        end
        else if (has_sig && ({1'b0, end_sig} > frame_len))
        begin
            status = ST_SIGNATURE;
        end
        else
        begin
            status = ST_OK;
        end
    end

    always_comb
    begin
        entry.has_byte    = emit;
        entry.byte_kind   = emit_kind;
        entry.data        = in_byte;
        entry.has_summary = in_last;
        entry.status      = status;
        entry.header      = hdr_next;
        push              = in_fire && (emit || in_last);
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (in_last)
        begin
            pos_next = '0;
        end
        else if (pos_reg < POS_MAX)
        begin
            pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            version_reg <= '0;
            hdr_reg     <= '0;
        end
        else if (in_fire)
        begin
            pos_reg <= pos_next;
            if (in_last)
            begin
                version_reg <= '0;
                hdr_reg     <= '0;
            end
            else
            begin
                version_reg <= version_next;
                hdr_reg     <= hdr_next;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/mfd_queue.sv
// ----------------------------------------------------------------------------
// mfd_queue
// Short queue of classified work between the front and the output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_queue
    import mfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     push,
    input  wire q_entry_t wr_entry,
    input  wire logic     pop,
    output q_entry_t      head,
    output logic          empty,
    output logic          full
);

    q_entry_t             slots_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   count_reg;
    logic                 do_push;
    logic                 do_pop;

    assign empty   = (count_reg == Q_CNT_W'(0));
    assign full    = (count_reg == Q_CNT_W'(Q_DEPTH));
    assign head    = slots_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= wr_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + Q_CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - Q_CNT_W'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hdl/mfd_back.sv
// ----------------------------------------------------------------------------
// mfd_back
// Output stage: unpacks queued work into byte and summary items and holds
// each item in a register until the sink takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module mfd_back
    import mfd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire q_entry_t head,
    input  wire logic     empty,
    output logic          pop,
    output logic          out_valid,
    input  wire logic     out_ready,
    output result_t       result
);

    logic    valid_reg, valid_next;
    logic    phase_reg, phase_next;
    result_t result_reg, result_next;
    logic    load;

    assign load      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign result    = result_reg;

    always_comb
    begin
        valid_next  = valid_reg;
        phase_next  = phase_reg;
        result_next = result_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                if (head.has_byte && !phase_reg)
                begin
                    result_next.kind     = head.byte_kind;
                    result_next.out_byte = head.data;
                    result_next.status   = ST_OK;
                    result_next.header   = '0;
                    result_next.last     = 1'b0;
                    if (head.has_summary)
                    begin
                        phase_next = 1'b1;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
                else
                begin
                    result_next.kind     = KIND_SUMMARY;
                    result_next.out_byte = 8'd0;
                    result_next.status   = head.status;
                    result_next.header   = head.header;
                    result_next.last     = 1'b1;
                    pop                  = 1'b1;
                    phase_next           = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

endmodule

`default_nettype wire

### hdl/message_frame_deframer.sv
// ----------------------------------------------------------------------------
// message_frame_deframer
// Splits a received message buffer into recipient, payload and signature
// byte items and ends each buffer with a summary item carrying a status.
// ----------------------------------------------------------------------------
// The block takes one buffer byte per cycle on the slave stream while the
// queue has room and ends a buffer on the byte marked with tlast. The output
// register sends one item per cycle while the sink is ready, so a final byte
// that is itself streamed yields two items. A two-entry queue between the
// front and the output register lets input continue while the sink stalls,
// and the slave tready drops only once that queue is full. A result passes
// through a queue slot and then the output register after its byte is taken.
// Configuration writes take effect on the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module message_frame_deframer
    import mfd_pkg::*;
#(
    parameter int SENDER_ID_BYTES    = 8,
    parameter int RECIPIENT_ID_BYTES = 8,
    parameter int SIGNATURE_BYTES    = 64
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    // in_byte[7:0]
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    // out_byte[7:0], status[10:8], frame_type[18:11], hop_limit[26:19],
    // time_stamp[90:27], flag_bits[98:91], body_length[114:99],
    // sender[178:115], zero pad[183:179]
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                  m_axis_tuser,
    output logic                        m_axis_tlast,
    input  wire logic                   cfg_we,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t     cfg_reg;
    logic     q_full;
    logic     q_empty;
    logic     q_push;
    logic     q_pop;
    q_entry_t q_in;
    q_entry_t q_head;
    result_t  result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.expected_version <= 8'd1;
            cfg_reg.recipient_mask   <= 8'd1;
            cfg_reg.signature_mask   <= 8'd2;
            cfg_reg.max_payload      <= 16'd256;
        end
        else if (cfg_we)
        begin
            case (reg_index_t'(cfg_index))
                REG_EXPECTED_VERSION: cfg_reg.expected_version <= cfg_data[7:0];
                REG_RECIPIENT_MASK:   cfg_reg.recipient_mask   <= cfg_data[7:0];
                REG_SIGNATURE_MASK:   cfg_reg.signature_mask   <= cfg_data[7:0];
                REG_MAX_PAYLOAD:      cfg_reg.max_payload      <= cfg_data;
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    mfd_front #(
        .SENDER_ID_BYTES    (SENDER_ID_BYTES),
        .RECIPIENT_ID_BYTES (RECIPIENT_ID_BYTES),
        .SIGNATURE_BYTES    (SIGNATURE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_byte  (s_axis_tdata[7:0]),
        .in_last  (s_axis_tlast),
        .q_full   (q_full),
        .push     (q_push),
        .entry    (q_in)
    );

    mfd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .wr_entry (q_in),
        .pop      (q_pop),
        .head     (q_head),
        .empty    (q_empty),
        .full     (q_full)
    );

    mfd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (q_head),
        .empty     (q_empty),
        .pop       (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .result    (result)
    );

    assign m_axis_tdata = {
        {OUT_PAD_W{1'b0}},
        result.header.sender,
        result.header.body_length,
        result.header.flag_bits,
        result.header.time_stamp,
        result.header.hop_limit,
        result.header.frame_type,
        result.status,
        result.out_byte
    };
    assign m_axis_tuser = result.kind;
    assign m_axis_tlast = result.last;

endmodule

`default_nettype wire
